// File: rtl/tcw_pkg.sv
// Types, constants and address helpers shared by the text console writer.
package tcw_pkg;

	localparam int SCREEN_WIDTH  = 80;
	localparam int SCREEN_HEIGHT = 25;
	localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W        = $clog2(CELL_COUNT);
	localparam int CELL_W        = 16;
	localparam int ROW_W         = 5;
	localparam int COL_W         = 7;
	localparam int COLOR_W       = 4;
	localparam int CHAR_W        = 8;

	localparam logic [ROW_W-1:0]  ROW_LIMIT  = ROW_W'(SCREEN_HEIGHT);
	localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(SCREEN_HEIGHT - 1);
	localparam logic [COL_W-1:0]  COL_LIMIT  = COL_W'(SCREEN_WIDTH);
	localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] ROW_SPAN   = ADDR_W'(SCREEN_WIDTH - 1);

	localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
	localparam logic [COLOR_W-1:0] FG_RESET     = 4'h7;
	localparam logic [COLOR_W-1:0] BG_RESET     = 4'h0;
	localparam logic [CELL_W-1:0]  RESET_CELL   = {BG_RESET, FG_RESET, BLANK_CHAR};

	typedef enum logic [1:0] {
		FN_PUT   = 2'd0,
		FN_READ  = 2'd1,
		FN_CLEAR = 2'd2,
		FN_NOP   = 2'd3
	} tcw_func_t;

	typedef enum logic {
		REG_FG = 1'b0,
		REG_BG = 1'b1
	} tcw_reg_t;

	typedef enum logic [3:0] {
		ST_INIT = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_READ = 4'b0100,
		ST_FILL = 4'b1000
	} tcw_state_t;

	typedef struct packed {
		tcw_func_t          func;
		logic [CHAR_W-1:0]  char_code;
		logic [ROW_W-1:0]   read_row;
		logic [COL_W-1:0]   read_col;
	} tcw_req_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_value;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
	} tcw_rsp_t;

	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
			input logic [ROW_W-1:0] top);
		logic [ROW_W:0] sum;
		sum = {1'b0, row} + {1'b0, top};
		if (sum >= {1'b0, ROW_LIMIT}) begin
			sum = sum - {1'b0, ROW_LIMIT};
		end
		return sum[ROW_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] prow);
		return ADDR_W'(prow * SCREEN_WIDTH);
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
			input logic [COL_W-1:0] col);
		return row_base(prow) + ADDR_W'(col);
	endfunction

endpackage

// File: rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/text_console_writer_core.sv
// Text console writer: screen store, cursor, scroll and clear sequencing.
//
//  channel  | signals                         | direction | payload
//  ---------+---------------------------------+-----------+-------------------------
//  request  | req_valid / req_ready / req     | in        | func, char, read row/col
//  response | rsp_valid / rsp_ready / rsp     | out       | cell, cursor row/col
//  config   | cfg_we / cfg_index / cfg_data   | in        | fg / bg colour
//
//  Put, newline without scroll and unused func: response in the cycle after accept.
//  Read: the RAM read data is registered, then taken into the response in ST_READ. The screen is a circular row buffer.
//  Scroll: blank one row in ST_FILL, one write per cycle, then respond.
//  Clear: blank the whole store in ST_FILL (one write per cell), then respond.
//  After reset the store is blanked in ST_INIT before the first request is taken;
//  one request is in flight at a time.
module text_console_writer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  tcw_pkg::tcw_req_t                 req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output tcw_pkg::tcw_rsp_t                 rsp,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [tcw_pkg::COLOR_W-1:0]       cfg_data
);

	import tcw_pkg::*;

	tcw_state_t          state_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    top_q;
	logic [COLOR_W-1:0]  fg_q;
	logic [COLOR_W-1:0]  bg_q;
	logic [ADDR_W-1:0]   fill_addr_q;
	logic [ADDR_W-1:0]   fill_last_q;
	logic [CELL_W-1:0]   fill_data_q;
	logic                rd_ok_q;
	logic                rsp_valid_q;
	tcw_rsp_t            rsp_q;

	logic                accept;
	logic                is_nl;
	logic [COL_W-1:0]    col_inc;
	logic                adv_row;
	logic                scroll;
	logic [ROW_W-1:0]    row_n;
	logic [COL_W-1:0]    col_n;
	logic [ROW_W-1:0]    top_n;
	logic                rd_ok;
	logic [ADDR_W-1:0]   rd_addr;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [CELL_W-1:0]   mem_wdata;
	logic                mem_re;
	logic [CELL_W-1:0]   mem_rdata;
	logic [CELL_W-1:0]   blank_cell;
	logic                fill_done;

	assign req_ready  = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept     = req_valid && req_ready;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign blank_cell = {bg_q, fg_q, BLANK_CHAR};
	assign fill_done  = (fill_addr_q == fill_last_q);

	always_comb begin
		is_nl   = (req.char_code == NEWLINE_CHAR);
		col_inc = col_q + COL_W'(1);
		adv_row = is_nl || (col_inc == COL_LIMIT);
		scroll  = adv_row && (row_q == ROW_LAST);
		row_n   = (adv_row && !scroll) ? row_q + ROW_W'(1) : row_q;
		col_n   = adv_row ? '0 : col_inc;
		top_n   = (top_q == ROW_LAST) ? '0 : top_q + ROW_W'(1);
		rd_ok   = (req.read_row < ROW_LIMIT) && (req.read_col < COL_LIMIT);
		rd_addr = rd_ok ? cell_addr(phys_row(req.read_row, top_q), req.read_col) : '0;
		mem_re  = accept && (req.func == FN_READ);

		mem_we    = 1'b0;
		mem_waddr = fill_addr_q;
		mem_wdata = fill_data_q;
		if (state_q == ST_INIT || state_q == ST_FILL) begin
			mem_we = 1'b1;
		end else if (accept && req.func == FN_PUT && !is_nl) begin
			mem_we    = 1'b1;
			mem_waddr = cell_addr(phys_row(row_q, top_q), col_q);
			mem_wdata = {bg_q, fg_q, req.char_code};
		end
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rd_addr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FG: fg_q <= cfg_data;
				REG_BG: bg_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			row_q       <= '0;
			col_q       <= '0;
			top_q       <= '0;
			fill_addr_q <= '0;
			fill_last_q <= ADDR_LAST;
			fill_data_q <= RESET_CELL;
			rd_ok_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					fill_addr_q <= fill_addr_q + ADDR_W'(1);
					if (fill_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						rsp_q.cell_value <= '0;
						rsp_q.cursor_row <= row_q;
						rsp_q.cursor_col <= col_q;
						unique case (req.func)
							FN_PUT: begin
								row_q            <= row_n;
								col_q            <= col_n;
								rsp_q.cursor_row <= row_n;
								rsp_q.cursor_col <= col_n;
								if (scroll) begin
									top_q       <= top_n;
									fill_addr_q <= row_base(top_q);
									fill_last_q <= row_base(top_q) + ROW_SPAN;
									fill_data_q <= blank_cell;
									state_q     <= ST_FILL;
								end else begin
									rsp_valid_q <= 1'b1;
								end
							end
							FN_READ: begin
								rd_ok_q <= rd_ok;
								state_q <= ST_READ;
							end
							FN_CLEAR: begin
								row_q            <= '0;
								col_q            <= '0;
								top_q            <= '0;
								rsp_q.cursor_row <= '0;
								rsp_q.cursor_col <= '0;
								fill_addr_q      <= '0;
								fill_last_q      <= ADDR_LAST;
								fill_data_q      <= blank_cell;
								state_q          <= ST_FILL;
							end
							FN_NOP: begin
								rsp_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_READ: begin
					rsp_q.cell_value <= rd_ok_q ? mem_rdata : '0;
					rsp_valid_q      <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_FILL: begin
					fill_addr_q <= fill_addr_q + ADDR_W'(1);
					if (fill_done) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q < ROW_LIMIT) && (col_q < COL_LIMIT) && (top_q < ROW_LIMIT))
		else $error("cursor or top row out of range");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !mem_we)
		else $error("store written while read data pending");

	a_fill_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL || state_q == ST_INIT) |-> (fill_addr_q <= fill_last_q))
		else $error("fill address passed its last cell");

	a_no_rsp_during_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL || state_q == ST_READ) |-> !rsp_valid_q)
		else $error("response pending while request still in work");

endmodule

// File: dv/tcw_console_checker.sv
// Checker for the text console writer: tracks screen and cursor, compares each response.
`timescale 1ns / 1ps

module tcw_console_checker
	import tcw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_ready,
	input  tcw_req_t             req,
	input  logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  tcw_rsp_t             rsp,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data,
	output int                   mismatch_count,
	output int                   rsp_outstanding
);

	logic [CELL_W-1:0]  screen_image [CELL_COUNT];
	logic [ROW_W-1:0]   cur_row;
	logic [COL_W-1:0]   cur_col;
	logic [COLOR_W-1:0] fg_now;
	logic [COLOR_W-1:0] bg_now;
	tcw_rsp_t           console_rsp_q [$];

	function automatic logic [CELL_W-1:0] colored_cell(input logic [CHAR_W-1:0] ch);
		return {bg_now, fg_now, ch};
	endfunction

	function automatic int cell_index(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
		return int'(row) * SCREEN_WIDTH + int'(col);
	endfunction

	function automatic void blank_screen();
		for (int i = 0; i < CELL_COUNT; i++) begin
			screen_image[i] = colored_cell(BLANK_CHAR);
		end
	endfunction

	function automatic void next_line();
		if (cur_row == ROW_LAST) begin
			for (int i = SCREEN_WIDTH; i < CELL_COUNT; i++) begin
				screen_image[i - SCREEN_WIDTH] = screen_image[i];
			end
			for (int i = CELL_COUNT - SCREEN_WIDTH; i < CELL_COUNT; i++) begin
				screen_image[i] = colored_cell(BLANK_CHAR);
			end
		end else begin
			cur_row = cur_row + 1'b1;
		end
	endfunction

	function automatic tcw_rsp_t predict_console(input tcw_req_t r);
		logic [CELL_W-1:0] cell_val;
		cell_val = '0;
		case (r.func)
			FN_PUT: begin
				if (r.char_code == NEWLINE_CHAR) begin
					next_line();
					cur_col = '0;
				end else begin
					screen_image[cell_index(cur_row, cur_col)] = colored_cell(r.char_code);
					if (cur_col == COL_LIMIT - 1'b1) begin
						cur_col = '0;
						next_line();
					end else begin
						cur_col = cur_col + 1'b1;
					end
				end
			end
			FN_READ: begin
				if (r.read_row < ROW_LIMIT && r.read_col < COL_LIMIT) begin
					cell_val = screen_image[cell_index(r.read_row, r.read_col)];
				end
			end
			FN_CLEAR: begin
				blank_screen();
				cur_row = '0;
				cur_col = '0;
			end
			default: begin
			end
		endcase
		return '{cell_value: cell_val, cursor_row: cur_row, cursor_col: cur_col};
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t MISMATCH %s", $time, msg);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		tcw_rsp_t want;
		if (!arst_n) begin
			fg_now = FG_RESET;
			bg_now = BG_RESET;
			cur_row = '0;
			cur_col = '0;
			blank_screen();
			console_rsp_q.delete();
			mismatch_count = 0;
			rsp_outstanding = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (console_rsp_q.size() == 0) begin
					report_mismatch($sformatf("response with none pending: %h", rsp));
				end else begin
					want = console_rsp_q.pop_front();
					if (rsp.cell_value !== want.cell_value) begin
						report_mismatch($sformatf("cell_value got %h want %h",
							rsp.cell_value, want.cell_value));
					end
					if (rsp.cursor_row !== want.cursor_row) begin
						report_mismatch($sformatf("cursor_row got %0d want %0d",
							rsp.cursor_row, want.cursor_row));
					end
					if (rsp.cursor_col !== want.cursor_col) begin
						report_mismatch($sformatf("cursor_col got %0d want %0d",
							rsp.cursor_col, want.cursor_col));
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_FG) begin
					fg_now = cfg_data;
				end else begin
					bg_now = cfg_data;
				end
			end
			if (req_valid && req_ready) begin
				console_rsp_q.push_back(predict_console(req));
			end
			rsp_outstanding = console_rsp_q.size();
		end
	end

endmodule

// File: dv/tb_text_console_writer_core.sv
// Testbench top for the text console writer: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_text_console_writer_core;
	import tcw_pkg::*;

	localparam int STALL_LIMIT = 12000;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 110;

	localparam logic [COLOR_W-1:0] FG_PLAN [PHASES] = '{4'hF, 4'h0, 4'h0, 4'hF, 4'h0};
	localparam logic [COLOR_W-1:0] BG_PLAN [PHASES] = '{4'hF, 4'h0, 4'h0, 4'h0, 4'hF};
	localparam int NEWLINE_PLAN [PHASES] = '{40, 1, 15, 30, 5};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	tcw_req_t           req = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	tcw_rsp_t           rsp;
	logic               cfg_we = 1'b0;
	tcw_reg_t           cfg_index = REG_FG;
	logic [COLOR_W-1:0] cfg_data = '0;
	logic               quiet = 1'b0;
	int                 mismatch_count;
	int                 rsp_outstanding;
	int                 idle_cycles = 0;

	text_console_writer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tcw_console_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.rsp             (rsp),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.rsp_outstanding (rsp_outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ready <= quiet || ($urandom_range(99) >= 20);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[text_console_writer_core] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic tcw_req_t make_req(input tcw_func_t f, input logic [CHAR_W-1:0] ch,
			input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
		return '{func: f, char_code: ch, read_row: row, read_col: col};
	endfunction

	function automatic tcw_req_t random_request(input int newline_pct);
		tcw_req_t r;
		int pick;
		r = make_req(FN_PUT, 8'($urandom), 5'($urandom), 7'($urandom));
		pick = $urandom_range(999);
		if (pick < 3) begin
			r.func = FN_CLEAR;
		end else if (pick < 25) begin
			r.func = FN_NOP;
		end else if (pick < 275) begin
			r.func = FN_READ;
			if ($urandom_range(99) >= 10) begin
				r.read_row = 5'($urandom_range(SCREEN_HEIGHT - 1));
				r.read_col = 7'($urandom_range(SCREEN_WIDTH - 1));
			end
		end else if ($urandom_range(99) < newline_pct) begin
			r.char_code = NEWLINE_CHAR;
		end
		return r;
	endfunction

	task automatic send_req(input tcw_req_t item);
		while (!quiet && $urandom_range(99) < 20) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(negedge clk);
		while (!req_ready) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (rsp_outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_colors(input logic [COLOR_W-1:0] fg_val, input logic [COLOR_W-1:0] bg_val);
		drain_responses();
		cfg_we <= 1'b1;
		cfg_index <= REG_FG;
		cfg_data <= fg_val;
		@(posedge clk);
		cfg_index <= REG_BG;
		cfg_data <= bg_val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [COLOR_W-1:0] fg_pick;
		logic [COLOR_W-1:0] bg_pick;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_req(make_req(FN_READ, 8'h00, 5'd0, 7'd0));
		send_req(make_req(FN_READ, 8'hFF, ROW_LAST, COL_LIMIT - 1'b1));
		send_req(make_req(FN_READ, 8'h00, ROW_LIMIT, 7'd0));
		send_req(make_req(FN_READ, 8'h00, 5'd0, COL_LIMIT));
		send_req(make_req(FN_READ, 8'h00, 5'h1F, 7'h7F));
		send_req(make_req(FN_PUT, 8'h00, 5'h1F, 7'h7F));
		send_req(make_req(FN_PUT, 8'hFF, 5'd0, 7'd0));
		send_req(make_req(FN_PUT, 8'h41, 5'd0, 7'd0));
		send_req(make_req(FN_READ, 8'h00, 5'd0, 7'd1));
		send_req(make_req(FN_READ, 8'h00, 5'd0, 7'd2));
		send_req(make_req(FN_NOP, 8'hFF, 5'h1F, 7'h7F));
		send_req(make_req(FN_PUT, NEWLINE_CHAR, 5'd0, 7'd0));
		send_req(make_req(FN_PUT, BLANK_CHAR, 5'd0, 7'd0));
		send_req(make_req(FN_READ, 8'h00, 5'd1, 7'd0));
		send_req(make_req(FN_READ, 8'h00, 5'd0, 7'd3));
		send_req(make_req(FN_CLEAR, 8'hFF, 5'h1F, 7'h7F));
		send_req(make_req(FN_READ, 8'h00, 5'd0, 7'd0));

		for (int p = 0; p < PHASES; p++) begin
			fg_pick = (p == 2) ? 4'($urandom) : FG_PLAN[p];
			bg_pick = (p == 2) ? 4'($urandom) : BG_PLAN[p];
			set_colors(fg_pick, bg_pick);
			quiet <= (p == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_req(random_request(NEWLINE_PLAN[p]));
			end
		end

		quiet <= 1'b0;
		drain_responses();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && rsp_outstanding == 0) begin
			$display("[text_console_writer_core] OK");
		end else begin
			$display("[text_console_writer_core] ERROR");
		end
		$finish;
	end

endmodule
